>>> design/dit_pkg.sv
// Package for the disjoint interval tracker: widths, op codes, sequencer states
// and the result type of the word scan unit. No dependencies.
package dit_pkg;

  localparam int VALUE_RANGE = 1024;
  localparam int VAL_W       = 10;
  localparam int WORD_W      = 32;
  localparam int IDX_W       = $clog2(WORD_W);
  localparam int NUM_WORDS   = VALUE_RANGE / WORD_W;
  localparam int WADDR_W     = $clog2(NUM_WORDS);

  localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(NUM_WORDS - 1);

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_PREV_RD,
    ST_PREV_EV,
    ST_Q_RD,
    ST_Q_EV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] idx;
  } scan_res_t;

endpackage

>>> design/dit_if.sv
// Channel interfaces of the disjoint interval tracker: input and result streams
// with valid/ready handshake. Depends on dit_pkg.
interface dit_in_if
  import dit_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             op;
  logic [VAL_W-1:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

interface dit_out_if
  import dit_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             found;
  logic [VAL_W-1:0] interval_start;
  logic [VAL_W-1:0] interval_stop;

  modport source (output valid, output found, output interval_start,
                  output interval_stop, input ready);
  modport sink   (input valid, input found, input interval_start,
                  input interval_stop, output ready);
endinterface

>>> design/dit_scan.sv
// Shared word scan unit: lowest set bit of a bitmap word at or above a bit index.
// Depends on dit_pkg.
module dit_scan
  import dit_pkg::*;
(
  input  logic [WORD_W-1:0] vec,
  input  logic [IDX_W-1:0]  lo,
  output scan_res_t         res
);

  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] lowest;
  logic [IDX_W-1:0]  idx;

  always_comb begin
    for (int i = 0; i < WORD_W; i++) begin
      masked[i] = vec[i] && (IDX_W'(i) >= lo);
    end
    lowest = masked & (~masked + WORD_W'(1));
    idx    = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        idx = idx | IDX_W'(i);
      end
    end
    res.hit = |masked;
    res.idx = idx;
  end

endmodule

>>> design/disjoint_interval_tracker.sv
// Top level of the disjoint interval tracker: presence bitmap memory, sequencer
// and output register. Depends on dit_pkg, dit_if and dit_scan.
//
// Usage:
//   in_ch  (sink)   : op = add (value marks a present integer) or query (value is a
//                     cursor). A transaction completes when valid and ready are high.
//   out_ch (source) : one transaction per query: found, interval_start,
//                     interval_stop of the first run starting at or after the cursor;
//                     zeros when found is low. Adds give no result.
// The set is held as a 1024-bit bitmap in 32 words of 32 bits, one word read per
// visit. An add is a read-modify-write: in_ch.ready is low while the word is read
// and written back (ADD_RD, ADD_WR), so a new add waits until the write is done.
// A query visits one word at a time (read, then scan): an optional look at the
// word below the cursor, the words up to the run start, the start word again and
// the words up to the run end, at most 33 visits in all. One item is in flight at
// a time; in_ch.ready is low meanwhile.
// Reset clears the per-word valid flags, so the set is empty right away; no
// clearing pass is needed. A stalled receiver holds the result in the output
// register; a finished query then waits until the register frees up.
module disjoint_interval_tracker
  import dit_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dit_in_if.sink    in_ch,
  dit_out_if.source out_ch
);

  logic [WORD_W-1:0]    mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] wvalid_r;
  logic [WORD_W-1:0]    rdata_r;
  logic                 rvalid_r;
  logic [WADDR_W-1:0]   raddr;
  logic                 mem_we;
  logic [WORD_W-1:0]    eff;

  state_t             state_r, state_nxt;
  logic [WADDR_W-1:0] word_r, word_nxt;
  logic [IDX_W-1:0]   lo_r, lo_nxt;
  logic               prev_msb_r, prev_msb_nxt;
  logic               seek_stop_r, seek_stop_nxt;
  logic [VAL_W-1:0]   start_r, start_nxt;
  logic               res_found_r, res_found_nxt;
  logic [VAL_W-1:0]   res_stop_r, res_stop_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r, out_found_nxt;
  logic [VAL_W-1:0]   out_start_r, out_start_nxt;
  logic [VAL_W-1:0]   out_stop_r, out_stop_nxt;

  logic [WORD_W-1:0] scan_vec;
  scan_res_t         scan;
  logic [VAL_W-1:0]  hit_val;

  assign eff     = rvalid_r ? rdata_r : '0;
  assign raddr   = (state_r == ST_PREV_RD) ? word_r - WADDR_W'(1) : word_r;
  assign mem_we  = (state_r == ST_ADD_WR);
  assign hit_val = {word_r, scan.idx};

  always_comb begin
    if (seek_stop_r) begin
      scan_vec = ~eff;
    end else begin
      scan_vec = eff & ~{eff[WORD_W-2:0], prev_msb_r};
    end
  end

  dit_scan u_scan (
    .vec (scan_vec),
    .lo  (lo_r),
    .res (scan)
  );

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[word_r] <= eff | (WORD_W'(1) << lo_r);
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wvalid_r <= '0;
      rvalid_r <= 1'b0;
    end else begin
      if (mem_we) begin
        wvalid_r[word_r] <= 1'b1;
      end
      rvalid_r <= wvalid_r[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    lo_r        <= lo_nxt;
    prev_msb_r  <= prev_msb_nxt;
    seek_stop_r <= seek_stop_nxt;
    start_r     <= start_nxt;
    res_found_r <= res_found_nxt;
    res_stop_r  <= res_stop_nxt;
    out_found_r <= out_found_nxt;
    out_start_r <= out_start_nxt;
    out_stop_r  <= out_stop_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    word_nxt      = word_r;
    lo_nxt        = lo_r;
    prev_msb_nxt  = prev_msb_r;
    seek_stop_nxt = seek_stop_r;
    start_nxt     = start_r;
    res_found_nxt = res_found_r;
    res_stop_nxt  = res_stop_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_start_nxt = out_start_r;
    out_stop_nxt  = out_stop_r;
    in_ch.ready   = 1'b0;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          word_nxt      = in_ch.value[VAL_W-1 -: WADDR_W];
          lo_nxt        = in_ch.value[IDX_W-1:0];
          prev_msb_nxt  = 1'b0;
          seek_stop_nxt = 1'b0;
          if (in_ch.op == OP_ADD) begin
            state_nxt = ST_ADD_RD;
          end else if (in_ch.value[VAL_W-1 -: WADDR_W] == '0) begin
            state_nxt = ST_Q_RD;
          end else begin
            state_nxt = ST_PREV_RD;
          end
        end
      end
      ST_ADD_RD: state_nxt = ST_ADD_WR;
      ST_ADD_WR: state_nxt = ST_IDLE;
      ST_PREV_RD: state_nxt = ST_PREV_EV;
      ST_PREV_EV: begin
        prev_msb_nxt = eff[WORD_W-1];
        state_nxt    = ST_Q_RD;
      end
      ST_Q_RD: state_nxt = ST_Q_EV;
      ST_Q_EV: begin
        state_nxt = ST_Q_RD;
        if (!seek_stop_r) begin
          if (scan.hit) begin
            start_nxt     = hit_val;
            lo_nxt        = scan.idx;
            seek_stop_nxt = 1'b1;
          end else if (word_r == LAST_WORD) begin
            res_found_nxt = 1'b0;
            state_nxt     = ST_DONE;
          end else begin
            prev_msb_nxt = eff[WORD_W-1];
            word_nxt     = word_r + WADDR_W'(1);
            lo_nxt       = '0;
          end
        end else begin
          if (scan.hit) begin
            res_found_nxt = 1'b1;
            res_stop_nxt  = hit_val - VAL_W'(1);
            state_nxt     = ST_DONE;
          end else if (word_r == LAST_WORD) begin
            res_found_nxt = 1'b1;
            res_stop_nxt  = VAL_W'(VALUE_RANGE - 1);
            state_nxt     = ST_DONE;
          end else begin
            word_nxt = word_r + WADDR_W'(1);
            lo_nxt   = '0;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_start_nxt = res_found_r ? start_r : '0;
          out_stop_nxt  = res_found_r ? res_stop_r : '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.interval_start = out_start_r;
  assign out_ch.interval_stop  = out_stop_r;

`ifndef SYNTH
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.found) |->
      (out_ch.interval_start == '0 && out_ch.interval_stop == '0))
    else $error("empty result with nonzero bounds");

  a_run_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.found) |->
      (out_ch.interval_stop >= out_ch.interval_start))
    else $error("run stop below run start");

  a_add_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_ADD && !out_ch.valid) |=>
      !out_ch.valid)
    else $error("add produced a result");

  a_done_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_DONE) |-> $past(state_r) == ST_Q_EV)
    else $error("result stage entered outside scan");
`endif

endmodule

>>> tb/tb.sv
// Testbench for disjoint_interval_tracker: directed table plus random add/query traffic,
// each query checked against the table's run or a bitmap predictor of the run list.
// Depends on dit_pkg, dit_if and the design files.
module tb;
  import dit_pkg::*;

  localparam int ITEMS        = 1050;
  localparam int QUIET_TAIL   = 120;
  localparam int DRAIN_CYCLES = 100;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] lo;
    logic [VAL_W-1:0] hi;
  } run_t;

  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] value;
    logic             typed;
    run_t             want;
  } dir_row_t;

  localparam run_t NO_RUN = '0;

  localparam dir_row_t DIRECTED [25] = '{
    '{OP_QUERY, 10'd0,    1'b1, NO_RUN},
    '{OP_QUERY, 10'd1023, 1'b1, NO_RUN},
    '{OP_ADD,   10'd0,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd0,    1'b1, '{1'b1, 10'd0, 10'd0}},
    '{OP_ADD,   10'd1023, 1'b0, NO_RUN},
    '{OP_QUERY, 10'd1,    1'b1, '{1'b1, 10'd1023, 10'd1023}},
    '{OP_ADD,   10'd1022, 1'b0, NO_RUN},
    '{OP_QUERY, 10'd1023, 1'b1, NO_RUN},
    '{OP_QUERY, 10'd1022, 1'b1, '{1'b1, 10'd1022, 10'd1023}},
    '{OP_ADD,   10'd1,    1'b0, NO_RUN},
    '{OP_ADD,   10'd1,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd0,    1'b1, '{1'b1, 10'd0, 10'd1}},
    '{OP_ADD,   10'd3,    1'b0, NO_RUN},
    '{OP_ADD,   10'd5,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd2,    1'b0, NO_RUN},
    '{OP_ADD,   10'd4,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd2,    1'b0, NO_RUN},
    '{OP_ADD,   10'd2,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd0,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd3,    1'b0, NO_RUN},
    '{OP_ADD,   10'd31,   1'b0, NO_RUN},
    '{OP_ADD,   10'd32,   1'b0, NO_RUN},
    '{OP_QUERY, 10'd6,    1'b0, NO_RUN},
    '{OP_QUERY, 10'd32,   1'b0, NO_RUN},
    '{OP_QUERY, 10'd1021, 1'b0, NO_RUN}
  };

  logic clk;
  logic rst_n;

  dit_in_if  in_ch();
  dit_out_if out_ch();

  disjoint_interval_tracker DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic [VALUE_RANGE-1:0] present_map;
  run_t                   pending_runs[$];
  int                     error_count;
  int                     items_sent;
  int                     adds_sent;
  int                     queries_sent;
  int                     results_seen;
  bit                     gaps_on;
  bit                     quiet_tail;

  initial begin
    clk = 1'b0;
  end

  always #1 clk = ~clk;

  function automatic run_t first_run_from(input int cursor);
    run_t r;
    int   e;
    r = NO_RUN;
    for (int s = cursor; s < VALUE_RANGE; s++) begin
      if (present_map[s] && (s == 0 || !present_map[s-1])) begin
        e = s;
        while (e + 1 < VALUE_RANGE && present_map[e+1]) e++;
        r.found = 1'b1;
        r.lo    = VAL_W'(s);
        r.hi    = VAL_W'(e);
        break;
      end
    end
    return r;
  endfunction

  task automatic idle_input(input int n);
    repeat (n) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
  endtask

  task automatic send_item(input logic op, input int value, input bit typed = 1'b0,
                           input run_t want = NO_RUN);
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.value <= VAL_W'(value);
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
    if (op == OP_ADD) begin
      present_map[value] = 1'b1;
      adds_sent++;
    end else begin
      pending_runs.insert(pending_runs.size(), typed ? want : first_run_from(value));
      queries_sent++;
    end
    if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0)
      idle_input($urandom_range(1, 18));
  endtask

  task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                             input logic [VAL_W-1:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    run_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_runs.size() == 0) begin
        error_count++;
        $display("%0t: unexpected transaction, expected none, actual found=%0b run %0d..%0d",
                 $time, out_ch.found, out_ch.interval_start, out_ch.interval_stop);
      end else begin
        want = pending_runs.pop_front();
        check_field("found", VAL_W'(want.found), VAL_W'(out_ch.found));
        check_field("interval_start", want.lo, out_ch.interval_start);
        check_field("interval_stop", want.hi, out_ch.interval_stop);
      end
    end
  end

  // result-side backpressure
  initial begin
    bit lvl;
    int n;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (quiet_tail || !gaps_on) begin
        @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        lvl = 1'($urandom_range(0, 1));
        n   = $urandom_range(1, 18);
        repeat (n) begin
          @(negedge clk);
          out_ch.ready <= lvl;
        end
      end
    end
  end

  initial begin
    int   base;
    int   len;
    int   stride;
    int   cursor;
    run_t r;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_ADD;
    in_ch.value  = '0;
    present_map  = '0;
    error_count  = 0;
    items_sent   = 0;
    adds_sent    = 0;
    queries_sent = 0;
    results_seen = 0;
    gaps_on      = 1'b1;
    quiet_tail   = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i])
      send_item(DIRECTED[i].op, DIRECTED[i].value, DIRECTED[i].typed, DIRECTED[i].want);

    while (items_sent < ITEMS) begin
      quiet_tail = items_sent >= ITEMS - QUIET_TAIL;
      gaps_on    = $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        0, 1: begin
          // run of adds, stride 2 leaves holes that later adds merge
          base   = $urandom_range(0, VALUE_RANGE - 1);
          len    = $urandom_range(1, 24);
          stride = $urandom_range(1, 2);
          for (int k = 0; k < len && base + k * stride < VALUE_RANGE; k++)
            send_item(OP_ADD, base + k * stride);
        end
        2: send_item(OP_ADD, $urandom_range(0, VALUE_RANGE - 1));
        3, 4: begin
          repeat ($urandom_range(1, 6))
            send_item(OP_QUERY, $urandom_range(0, VALUE_RANGE - 1));
        end
        5, 6: begin
          // cursor right at or next to a run edge
          r = first_run_from($urandom_range(0, VALUE_RANGE - 1));
          if (!r.found) begin
            cursor = $urandom_range(0, VALUE_RANGE - 1);
          end else begin
            case ($urandom_range(0, 4))
              0:       cursor = int'(r.lo) - 1;
              1:       cursor = int'(r.lo);
              2:       cursor = int'(r.lo) + 1;
              3:       cursor = int'(r.hi);
              default: cursor = int'(r.hi) + 1;
            endcase
            if (cursor < 0) cursor = 0;
            if (cursor > VALUE_RANGE - 1) cursor = VALUE_RANGE - 1;
          end
          send_item(OP_QUERY, cursor);
        end
        default: begin
          // list walk: restart each query just past the last run
          cursor = $urandom_range(0, 1) ? 0 : $urandom_range(0, VALUE_RANGE - 1);
          for (int k = 0; k < 12; k++) begin
            r = first_run_from(cursor);
            send_item(OP_QUERY, cursor);
            if (!r.found || r.hi == VALUE_RANGE - 1) break;
            cursor = int'(r.hi) + 1;
          end
        end
      endcase
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (pending_runs.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d transactions (%0d adds, %0d queries), checked %0d results.",
             items_sent, adds_sent, queries_sent, results_seen);
    $display("Set ended with %0d of %0d values present.", $countones(present_map), VALUE_RANGE);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #2000000;
    $display("Timeout with %0d results outstanding", pending_runs.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
